[rtl/core/depq_pkg.sv]
// Package for the double-ended priority queue: commands, states, sizes.
package depq_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned IO_BITS        = 32;
  localparam int unsigned COUNT_BITS     = 9;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_MIN = 2'd1,
    CMD_REMOVE_MAX = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_READ_ENDS,
    ST_READ_WAIT,
    ST_REPORT
  } state_t;

endpackage

[rtl/core/depq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module depq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/double_ended_priority_queue_unit.sv]
// Top level of the double-ended priority queue: sorted store plus sequencer.
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+---------------------------
//  in      | start, busy, in_cmd, in_value           | start high while busy low
//  out     | out_valid, out_largest, out_smallest,   | out_valid high, one cycle
//          | out_is_empty, out_entry_count, out_dropped |
//
// Entries sit in one RAM in ascending order (sign-flipped keys, unsigned compare).
// Insert: linear search with one comparator, then shift up each larger entry in turn.
// Remove smallest: shift each later entry down in turn. Remove largest and clear: count only.
// Every command ends reading both ends of the store (READ_ENDS, READ_WAIT, REPORT).
// Synchronous reset empties the queue at once; the result cannot be stalled.
module double_ended_priority_queue_unit #(
  parameter int unsigned CAPACITY   = depq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = depq_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [depq_pkg::CMD_BITS-1:0] in_cmd,
  input  logic signed [depq_pkg::IO_BITS-1:0] in_value,
  output logic                          out_valid,
  output logic signed [depq_pkg::IO_BITS-1:0] out_largest,
  output logic signed [depq_pkg::IO_BITS-1:0] out_smallest,
  output logic                          out_is_empty,
  output logic [depq_pkg::COUNT_BITS-1:0] out_entry_count,
  output logic                          out_dropped
);

  import depq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic drop_r, drop_nxt;
  logic [VALUE_BITS-1:0] max_r, max_nxt;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] wr_data, rd_data;
  logic [VALUE_BITS-1:0] in_raw;

  depq_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // sign-extend or truncate input to the stored width
  always_comb begin
    in_raw = VALUE_BITS'($signed(in_value));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    cmd_r  <= cmd_nxt;
    drop_r <= drop_nxt;
    max_r  <= max_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    cmd_nxt   = cmd_r;
    drop_nxt  = drop_r;
    max_nxt   = max_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = cmd_t'(in_cmd);
          key_nxt  = in_raw ^ SIGN;
          drop_nxt = 1'b0;
          idx_nxt  = '0;
          unique case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (occ_r == CW'(CAPACITY)) begin
                drop_nxt  = 1'b1;
                state_nxt = ST_READ_ENDS;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            CMD_REMOVE_MIN: begin
              if (occ_r == '0) begin
                state_nxt = ST_READ_ENDS;
              end else begin
                idx_nxt   = CW'(1);
                state_nxt = ST_SHIFT;
              end
            end
            CMD_REMOVE_MAX: begin
              if (occ_r != '0) begin
                occ_nxt = occ_r - 1'b1;
              end
              state_nxt = ST_READ_ENDS;
            end
            CMD_CLEAR: begin
              occ_nxt   = '0;
              state_nxt = ST_READ_ENDS;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        // rd_data holds entry idx_r-1 once idx_r > 0
        if (idx_r != '0 && rd_data > key_r) begin
          pos_nxt   = idx_r - 1'b1;
          idx_nxt   = occ_r;
          state_nxt = ST_SHIFT;
        end else if (idx_r == occ_r) begin
          pos_nxt   = occ_r;
          idx_nxt   = occ_r;
          state_nxt = ST_SHIFT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (cmd_r == CMD_INSERT) begin
          if (idx_r == pos_r) begin
            occ_nxt   = occ_r + 1'b1;
            state_nxt = ST_READ_ENDS;
          end else begin
            state_nxt = ST_SHIFT_WR;
          end
        end else begin
          if (idx_r == occ_r) begin
            occ_nxt   = occ_r - 1'b1;
            state_nxt = ST_READ_ENDS;
          end else begin
            state_nxt = ST_SHIFT_WR;
          end
        end
      end
      ST_SHIFT_WR: begin
        if (cmd_r == CMD_INSERT) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        state_nxt = ST_SHIFT;
      end
      ST_READ_ENDS: state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: begin
        max_nxt   = rd_data;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(idx_r);
    wr_data = rd_data;
    rd_addr = '0;
    unique case (state_r)
      ST_SEARCH: rd_addr = AW'(idx_r);
      ST_SHIFT: begin
        if (cmd_r == CMD_INSERT) begin
          rd_addr = AW'(idx_r - 1'b1);
          if (idx_r == pos_r) begin
            wr_en   = 1'b1;
            wr_data = key_r;
          end
        end else begin
          rd_addr = AW'(idx_r);
        end
      end
      ST_SHIFT_WR: begin
        wr_en = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          wr_addr = AW'(idx_r);
        end else begin
          wr_addr = AW'(idx_r - 1'b1);
        end
      end
      ST_READ_ENDS: rd_addr = AW'(occ_r - 1'b1);
      ST_READ_WAIT: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // result outputs
  logic [VALUE_BITS-1:0] lo_val, hi_val;
  always_comb begin
    hi_val = max_r ^ SIGN;
    lo_val = rd_data ^ SIGN;
    busy            = (state_r != ST_IDLE);
    out_valid       = (state_r == ST_REPORT);
    out_is_empty    = (occ_r == '0);
    out_entry_count = COUNT_BITS'(occ_r);
    out_dropped     = drop_r;
    if (occ_r == '0) begin
      out_largest  = '0;
      out_smallest = '0;
    end else begin
      out_largest  = IO_BITS'(hi_val);
      out_smallest = IO_BITS'(lo_val);
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY)) else $error("occupancy above capacity");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> occ_r == CW'(CAPACITY)) else $error("drop while not full");
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("no return to idle after result");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item not in progress");
`endif

endmodule
